// ----- design/crpe_pkg.sv -----
// Shared types, constants and control/status bundles for the Catmull-Rom path evaluator.
// No dependencies; every other design file except crpe_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package crpe_pkg;
  localparam int FRAC_BITS      = 16;
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_W        = 32;
  localparam int HW             = 48;                 // Horner / position working width
  localparam int TW             = FRAC_BITS + 1;      // local parameter 0..1 inclusive
  localparam int MW             = HW + TW + 1;        // Horner product width
  localparam int EPS_FX         = ((2 ** FRAC_BITS) + 500) / 1000;
  localparam int HALF_FX        = 2 ** (FRAC_BITS - 1);
  localparam int MAG_W          = COORD_W - 1;        // normalized magnitude width
  localparam int SQ_W           = 2 * MAG_W;
  localparam int SUM_W          = 64;
  localparam int ROOT_W         = 32;
  localparam int SQRT_STEPS     = 32;
  localparam int DIV_STEPS      = 18;
  localparam int Q_W            = DIV_STEPS;
  localparam int NUM_W          = MAG_W + FRAC_BITS + 1;
  localparam int DEN_W          = ROOT_W + DIV_STEPS - 1;
  localparam int TAPS           = 4;
  localparam int HORNER_STEPS   = 3;
  localparam int CNT_W          = 6;
  localparam int WORD_W         = 3 * COORD_W;

  typedef enum logic [1:0] {
    REQ_ADD, REQ_CLEAR, REQ_POS, REQ_DIR
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK, STAT_FULL, STAT_SAT
  } stat_t;

  typedef enum logic [1:0] {
    OUT_ZERO, OUT_FULL, OUT_POS, OUT_DIR
  } okind_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISP, ST_TCLAMP, ST_SEGMUL, ST_SEG, ST_READ, ST_COEF, ST_MUL, ST_ACC,
    ST_FIN, ST_DIFF, ST_MAX, ST_NORM, ST_SQ, ST_SQLD, ST_SQRT, ST_DIVLD, ST_DIV,
    ST_DIVEND, ST_OUT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       do_add;
    logic       do_clear;
    logic       tclamp;
    logic       segmul;
    logic       seg;
    logic       rd_issue;
    logic [1:0] rd_tap;
    logic       rd_cap;
    logic [1:0] cap_tap;
    logic       coef;
    logic       mul;
    logic       acc;
    logic [1:0] step;
    logic       fin;
    logic [1:0] comp;
    logic       pass;
    logic       diff;
    logic       maxc;
    logic       norm;
    logic       sq_mul;
    logic       sq_acc;
    logic       sqrt_ld;
    logic       sqrt_step;
    logic       div_ld;
    logic       div_step;
    logic       div_end;
    logic       load_out;
    okind_t     okind;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic cnt_zero;
    logic cnt_full;
    logic mx_zero;
    logic mx_hi;
    logic mx_lo;
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

// ----- design/catmull_rom_path_evaluator.sv -----
// Top level of the Catmull-Rom path evaluator: sequencer plus datapath.
// Depends on crpe_pkg, crpe_ctrl, crpe_dp (and crpe_ram below it).
//
// Usage: one request enters on the in_ channel (valid/stall; accepted when
// in_valid is high and in_stall low). Kinds: add a point, clear the store,
// position at t, unit direction at t. Every request yields exactly one
// result on the out_ channel (valid/stall) carrying x/y/z, the point count
// after the request and a status code.
// Add and clear go straight to the output load. A position query runs setup,
// four store reads, then per component one coefficient step, three
// multiply/accumulate pairs and one finish step on one shared multiplier,
// then the output load. A direction query runs two position passes, a
// one-bit-per-cycle normalizer, squaring and summing of the components, a
// 32-step square root and a divide per component, or ends early with a zero
// result when the difference is zero. One request is in flight at a time;
// the block returns to idle after each result. The next request is taken
// once the result sits in the output register, even while the receiver
// still stalls it. Reset (rst_n low, synchronous) empties the store, clears
// looping and drops any pending result. A stalled result holds; the block
// then waits. cfg_ready is always high: write looping only while idle.
`timescale 1ns / 1ps
`default_nettype none
module catmull_rom_path_evaluator
  import crpe_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic                               cfg_looping,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic signed [COORD_W-1:0]          in_pos_x,
  input  wire logic signed [COORD_W-1:0]          in_pos_y,
  input  wire logic signed [COORD_W-1:0]          in_pos_z,
  input  wire logic signed [COORD_W-1:0]          in_t_param,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [COORD_W-1:0]               out_x,
  output logic signed [COORD_W-1:0]               out_y,
  output logic signed [COORD_W-1:0]               out_z,
  output logic [$clog2(MAX_POINTS+1)-1:0]         out_stored_points,
  output logic [1:0]                              out_status
);
  localparam int CW = $clog2(MAX_POINTS + 1);

  cmd_t cmd;
  sts_t sts;

  // config writes are always accepted; looping is registered
  assign cfg_ready = 1'b1;

  crpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  crpe_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_valid         (cfg_valid && cfg_ready),
    .cfg_looping       (cfg_looping),
    .in_req_type       (in_req_type),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .in_t_param        (in_t_param),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_stored_points (out_stored_points),
    .out_status        (out_status)
  );

  // a taken request always keeps the input side closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after request accept");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stored_points <= CW'(MAX_POINTS))
    else $error("point count above store depth");

  // a dropped point is only reported with a full store
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_stored_points == CW'(MAX_POINTS))
    else $error("store-full status with free entries");
endmodule
`default_nettype wire

// ----- design/crpe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the control point store.
`timescale 1ns / 1ps
`default_nettype none
module crpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- design/crpe_ctrl.sv -----
// Sequencer for the path evaluator: issues datapath commands step by step.
// Depends on crpe_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none
module crpe_ctrl
  import crpe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire sts_t sts,
  output logic      in_stall,
  output cmd_t      cmd
);
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        comp_r, comp_nxt;
  logic              pass_r, pass_nxt;
  okind_t            okind_r, okind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      comp_r  <= '0;
      pass_r  <= 1'b0;
      okind_r <= OUT_ZERO;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      comp_r  <= comp_nxt;
      pass_r  <= pass_nxt;
      okind_r <= okind_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    comp_nxt  = comp_r;
    pass_nxt  = pass_r;
    okind_nxt = okind_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        okind_nxt = OUT_ZERO;
        pass_nxt  = 1'b0;
        case (sts.req)
          REQ_ADD: begin
            state_nxt = ST_OUT;
            if (sts.cnt_full) begin
              okind_nxt = OUT_FULL;
            end
          end
          REQ_CLEAR: state_nxt = ST_OUT;
          default: begin
            state_nxt = sts.cnt_zero ? ST_OUT : ST_TCLAMP;
          end
        endcase
      end
      ST_TCLAMP: state_nxt = ST_SEGMUL;
      ST_SEGMUL: state_nxt = ST_SEG;
      ST_SEG: begin
        state_nxt = ST_READ;
        cnt_nxt   = '0;
      end
      ST_READ: begin
        if (cnt_r == CNT_W'(TAPS)) begin
          state_nxt = ST_COEF;
          comp_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_COEF: begin
        state_nxt = ST_MUL;
        cnt_nxt   = '0;
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: begin
        if (cnt_r == CNT_W'(HORNER_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (comp_r == 2'd2) begin
          if (sts.req == REQ_POS) begin
            state_nxt = ST_OUT;
            okind_nxt = OUT_POS;
          end else if (!pass_r) begin
            pass_nxt  = 1'b1;
            state_nxt = ST_TCLAMP;
          end else begin
            state_nxt = ST_DIFF;
          end
        end else begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = ST_COEF;
        end
      end
      ST_DIFF: state_nxt = ST_MAX;
      ST_MAX:  state_nxt = ST_NORM;
      ST_NORM: begin
        if (sts.mx_zero) begin
          state_nxt = ST_OUT;
          okind_nxt = OUT_ZERO;
        end else if (!sts.mx_hi && !sts.mx_lo) begin
          state_nxt = ST_SQ;
          cnt_nxt   = '0;
        end
      end
      ST_SQ: begin
        if (cnt_r == CNT_W'(3)) begin
          state_nxt = ST_SQLD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQLD: begin
        state_nxt = ST_SQRT;
        cnt_nxt   = '0;
      end
      ST_SQRT: begin
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_DIVLD;
          comp_nxt  = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIVLD: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_DIVEND;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DIVEND: begin
        if (comp_r == 2'd2) begin
          state_nxt = ST_OUT;
          okind_nxt = OUT_DIR;
        end else begin
          comp_nxt  = comp_r + 1'b1;
          state_nxt = ST_DIVLD;
        end
      end
      ST_OUT: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    cmd.comp  = comp_r;
    cmd.pass  = pass_r;
    cmd.okind = okind_r;
    cmd.step  = cnt_r[1:0];
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:   cmd.accept = in_valid;
      ST_DISP: begin
        cmd.do_add   = (sts.req == REQ_ADD) && !sts.cnt_full;
        cmd.do_clear = (sts.req == REQ_CLEAR);
      end
      ST_TCLAMP: cmd.tclamp = 1'b1;
      ST_SEGMUL: cmd.segmul = 1'b1;
      ST_SEG:    cmd.seg    = 1'b1;
      ST_READ: begin
        cmd.rd_issue = (cnt_r < CNT_W'(TAPS));
        cmd.rd_tap   = cnt_r[1:0];
        cmd.rd_cap   = (cnt_r != '0);
        cmd.cap_tap  = cnt_r[1:0] - 2'd1;
      end
      ST_COEF:   cmd.coef = 1'b1;
      ST_MUL:    cmd.mul  = 1'b1;
      ST_ACC:    cmd.acc  = 1'b1;
      ST_FIN:    cmd.fin  = 1'b1;
      ST_DIFF:   cmd.diff = 1'b1;
      ST_MAX:    cmd.maxc = 1'b1;
      ST_NORM:   cmd.norm = 1'b1;
      ST_SQ: begin
        cmd.comp   = cnt_r[1:0];
        cmd.sq_mul = (cnt_r < CNT_W'(3));
        cmd.sq_acc = (cnt_r != '0);
      end
      ST_SQLD:   cmd.sqrt_ld   = 1'b1;
      ST_SQRT:   cmd.sqrt_step = 1'b1;
      ST_DIVLD:  cmd.div_ld    = 1'b1;
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_DIVEND: cmd.div_end   = 1'b1;
      ST_OUT:    cmd.load_out  = !sts.out_busy;
      default:   cmd.accept    = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/crpe_dp.sv -----
// Datapath: point store, Horner unit, normalizer, square root and divider, result register.
// Depends on crpe_pkg and crpe_ram; driven by commands from crpe_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module crpe_dp
  import crpe_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cmd_t                              cmd,
  output sts_t                                   sts,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_looping,
  input  wire logic [1:0]                        in_req_type,
  input  wire logic signed [COORD_W-1:0]         in_pos_x,
  input  wire logic signed [COORD_W-1:0]         in_pos_y,
  input  wire logic signed [COORD_W-1:0]         in_pos_z,
  input  wire logic signed [COORD_W-1:0]         in_t_param,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [COORD_W-1:0]              out_x,
  output logic signed [COORD_W-1:0]              out_y,
  output logic signed [COORD_W-1:0]              out_z,
  output logic [$clog2(MAX_POINTS+1)-1:0]        out_stored_points,
  output logic [1:0]                             out_status
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [TW-1:0] ONE_U = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic signed [HW-1:0] sx(input logic signed [COORD_W-1:0] v);
    return {{(HW - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] pick(input logic [WORD_W-1:0] w,
                                                     input logic [1:0] k);
    logic signed [COORD_W-1:0] r;
    case (k)
      2'd0:    r = w[3*COORD_W-1:2*COORD_W];
      2'd1:    r = w[2*COORD_W-1:COORD_W];
      default: r = w[COORD_W-1:0];
    endcase
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [HW-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (&v[HW-1:COORD_W-1] || ~|v[HW-1:COORD_W-1]) begin
      r = v[COORD_W-1:0];
    end else begin
      r = v[HW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  logic                        looping_r;
  logic [CW-1:0]               count_r;
  req_t                        req_r;
  logic signed [COORD_W-1:0]   tq_r;
  logic [WORD_W-1:0]           pin_r;
  logic [TW-1:0]               tc_r, tc_nxt;
  logic [TW+CW-1:0]            prod_r;
  logic [CW-1:0]               seg_r, seg_nxt;
  logic [TW-1:0]               u_r, u_nxt;
  logic [WORD_W-1:0]           pt_r [TAPS];
  logic signed [HW-1:0]        a_r, b_r, c_r, h_r, h_nxt;
  logic signed [MW-1:0]        mprod_r;
  logic signed [HW-1:0]        pa_r [3];
  logic signed [HW-1:0]        pb_r [3];
  logic                        neg_r [3];
  logic [HW-1:0]               m_r [3];
  logic [HW-1:0]               mx_r;
  logic [SQ_W-1:0]             sqp_r;
  logic [SUM_W-1:0]            sum_r, v_r, r_r, bit_r;
  logic [NUM_W-1:0]            rem_r;
  logic [DEN_W-1:0]            den_r;
  logic [Q_W-1:0]              q_r;
  logic signed [COORD_W-1:0]   dq_r [3];
  logic signed [COORD_W-1:0]   ox_r, oy_r, oz_r;
  logic [CW-1:0]               osp_r;
  stat_t                       ost_r;
  logic                        ovalid_r;

  logic                        single;
  logic signed [COORD_W:0]     te;
  logic [CW:0]                 seg_raw;
  logic signed [CW+1:0]        ni, nn;
  logic [AW-1:0]               rd_addr;
  logic [WORD_W-1:0]           rdata;
  logic signed [HW-1:0]        e0, e1, e2, e3, addend, posv;
  logic signed [MW-1:0]        rsum;
  logic [SUM_W:0]              trial;
  logic [ROOT_W-1:0]           root;
  logic signed [COORD_W-1:0]   sx_o, sy_o, sz_o;

  assign single = (count_r == CW'(1));
  assign root   = r_r[ROOT_W-1:0];

  // local parameter from t
  always_comb begin
    te = {tq_r[COORD_W-1], tq_r};
    if (req_r == REQ_DIR) begin
      te = cmd.pass ? te + (COORD_W+1)'(EPS_FX) : te - (COORD_W+1)'(EPS_FX);
    end
    if (looping_r) begin
      tc_nxt = {1'b0, te[FRAC_BITS-1:0]};
    end else if (te < 0) begin
      tc_nxt = '0;
    end else if (te > $signed({{(COORD_W-FRAC_BITS){1'b0}}, ONE_U})) begin
      tc_nxt = ONE_U;
    end else begin
      tc_nxt = te[TW-1:0];
    end
  end

  // segment and local u; the end of the path sits at u=1 of the last segment
  always_comb begin
    seg_raw = prod_r[TW+CW-1:FRAC_BITS];
    if (single) begin
      seg_nxt = '0;
      u_nxt   = '0;
    end else if (seg_raw >= {1'b0, count_r - CW'(1)}) begin
      seg_nxt = count_r - CW'(2);
      u_nxt   = ONE_U;
    end else begin
      seg_nxt = seg_raw[CW-1:0];
      u_nxt   = {1'b0, prod_r[FRAC_BITS-1:0]};
    end
  end

  // neighbor index: wrap or clamp
  always_comb begin
    nn = $signed({2'b00, count_r});
    ni = $signed({2'b00, seg_r}) + $signed({{CW{1'b0}}, cmd.rd_tap}) - (CW+2)'(1);
    if (single) begin
      ni = '0;
    end else if (looping_r) begin
      if (ni < 0) begin
        ni = ni + nn;
      end else if (ni >= nn) begin
        ni = ni - nn;
      end
    end else begin
      if (ni < 0) begin
        ni = '0;
      end else if (ni >= nn) begin
        ni = nn - (CW+2)'(1);
      end
    end
    rd_addr = ni[AW-1:0];
  end

  crpe_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.do_add),
    .waddr (count_r[AW-1:0]),
    .wdata (pin_r),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // Horner arithmetic
  always_comb begin
    e0 = sx(pick(pt_r[0], cmd.comp));
    e1 = sx(pick(pt_r[1], cmd.comp));
    e2 = sx(pick(pt_r[2], cmd.comp));
    e3 = sx(pick(pt_r[3], cmd.comp));
    case (cmd.step)
      2'd0:    addend = c_r;
      2'd1:    addend = b_r;
      default: addend = a_r;
    endcase
    rsum  = mprod_r + MW'(HALF_FX);
    h_nxt = $signed(rsum[FRAC_BITS+HW-1:FRAC_BITS]) + addend;
    posv  = (h_r + HW'(1)) >>> 1;
    trial = {1'b0, r_r} + {1'b0, bit_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      looping_r <= 1'b0;
      count_r   <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        looping_r <= cfg_looping;
      end
      if (cmd.do_add) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.do_clear) begin
        count_r <= '0;
      end
      if (cmd.load_out) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= req_t'(in_req_type);
      tq_r  <= in_t_param;
      pin_r <= {in_pos_x, in_pos_y, in_pos_z};
    end
    if (cmd.tclamp) begin
      tc_r <= tc_nxt;
    end
    if (cmd.segmul) begin
      prod_r <= (TW+CW)'(tc_r) * (TW+CW)'(count_r - CW'(1));
    end
    if (cmd.seg) begin
      seg_r <= seg_nxt;
      u_r   <= u_nxt;
    end
    if (cmd.rd_cap) begin
      pt_r[cmd.cap_tap] <= rdata;
    end
    if (cmd.coef) begin
      a_r <= e1 <<< 1;
      b_r <= e2 - e0;
      c_r <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      h_r <= ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2) + e3 - e0;
    end
    if (cmd.mul) begin
      mprod_r <= h_r * $signed({1'b0, u_r});
    end
    if (cmd.acc) begin
      h_r <= h_nxt;
    end
    if (cmd.fin) begin
      if (cmd.pass) begin
        pb_r[cmd.comp] <= posv;
      end else begin
        pa_r[cmd.comp] <= posv;
      end
    end
    if (cmd.diff) begin
      for (int k = 0; k < 3; k++) begin
        neg_r[k] <= (pb_r[k] < pa_r[k]);
        m_r[k]   <= (pb_r[k] < pa_r[k]) ? HW'(pa_r[k] - pb_r[k]) : HW'(pb_r[k] - pa_r[k]);
      end
    end
    if (cmd.maxc) begin
      if (m_r[0] >= m_r[1] && m_r[0] >= m_r[2]) begin
        mx_r <= m_r[0];
      end else if (m_r[1] >= m_r[2]) begin
        mx_r <= m_r[1];
      end else begin
        mx_r <= m_r[2];
      end
      sum_r <= '0;
    end
    // normalize one bit per cycle toward [2^30, 2^31)
    if (cmd.norm) begin
      if (sts.mx_hi) begin
        mx_r <= mx_r >> 1;
        for (int k = 0; k < 3; k++) begin
          m_r[k] <= m_r[k] >> 1;
        end
      end else if (sts.mx_lo && !sts.mx_zero) begin
        mx_r <= mx_r << 1;
        for (int k = 0; k < 3; k++) begin
          m_r[k] <= m_r[k] << 1;
        end
      end
    end
    if (cmd.sq_mul) begin
      sqp_r <= SQ_W'(m_r[cmd.comp][MAG_W-1:0]) * SQ_W'(m_r[cmd.comp][MAG_W-1:0]);
    end
    if (cmd.sq_acc) begin
      sum_r <= sum_r + SUM_W'(sqp_r);
    end
    if (cmd.sqrt_ld) begin
      v_r   <= sum_r;
      r_r   <= '0;
      bit_r <= {2'b01, {(SUM_W-2){1'b0}}};
    end
    if (cmd.sqrt_step) begin
      if ({1'b0, v_r} >= trial) begin
        v_r <= v_r - trial[SUM_W-1:0];
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_ld) begin
      rem_r <= {1'b0, m_r[cmd.comp][MAG_W-1:0], {FRAC_BITS{1'b0}}}
               + NUM_W'(root >> 1);
      den_r <= {root, {(DIV_STEPS-1){1'b0}}};
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if ({1'b0, rem_r} >= DEN_W'(den_r)) begin
        rem_r <= rem_r - den_r[NUM_W-1:0];
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
      den_r <= den_r >> 1;
    end
    if (cmd.div_end) begin
      dq_r[cmd.comp] <= neg_r[cmd.comp] ? -$signed(COORD_W'(q_r)) : $signed(COORD_W'(q_r));
    end
    if (cmd.load_out) begin
      osp_r <= count_r;
      case (cmd.okind)
        OUT_POS: begin
          ox_r  <= sx_o;
          oy_r  <= sy_o;
          oz_r  <= sz_o;
          ost_r <= (sx_o != pa_r[0][COORD_W-1:0] || sy_o != pa_r[1][COORD_W-1:0] ||
                    sz_o != pa_r[2][COORD_W-1:0]) ? STAT_SAT : STAT_OK;
        end
        OUT_DIR: begin
          ox_r  <= dq_r[0];
          oy_r  <= dq_r[1];
          oz_r  <= dq_r[2];
          ost_r <= STAT_OK;
        end
        OUT_FULL: begin
          ox_r  <= '0;
          oy_r  <= '0;
          oz_r  <= '0;
          ost_r <= STAT_FULL;
        end
        default: begin
          ox_r  <= '0;
          oy_r  <= '0;
          oz_r  <= '0;
          ost_r <= STAT_OK;
        end
      endcase
    end
  end

  assign sx_o = sat(pa_r[0]);
  assign sy_o = sat(pa_r[1]);
  assign sz_o = sat(pa_r[2]);

  always_comb begin
    sts.req      = req_r;
    sts.cnt_zero = (count_r == '0);
    sts.cnt_full = (count_r == CW'(MAX_POINTS));
    sts.mx_zero  = (mx_r == '0);
    sts.mx_hi    = |mx_r[HW-1:MAG_W];
    sts.mx_lo    = ~|mx_r[HW-1:MAG_W-1];
    sts.out_busy = ovalid_r && out_stall;
  end

  assign out_valid         = ovalid_r;
  assign out_x             = ox_r;
  assign out_y             = oy_r;
  assign out_z             = oz_r;
  assign out_stored_points = osp_r;
  assign out_status        = ost_r;
endmodule
`default_nettype wire
